// File: design/chunked_cell_pool_allocator_top_macros.svh
// assertion macros shared by the allocator checker
`ifndef CHUNKED_CELL_POOL_ALLOCATOR_TOP_MACROS_SVH
`define CHUNKED_CELL_POOL_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define CCPA_ASSERT_NOW(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication, disabled in reset
`define CCPA_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// File: design/ccpa_pkg.sv
// ----------------------------------------------------------------------------
// ccpa_pkg
// types and constants shared by the cell pool allocator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccpa_pkg;

  localparam int CELL_W = 10;
  localparam int CNT_W  = 11;
  localparam int CFG_IDX_W = 2;

  localparam int DEFAULT_POOL_CELLS = 1024;

  localparam logic [CNT_W-1:0] CHUNK_SIZE_RESET = 11'd64;
  localparam logic [CNT_W-1:0] CELL_LIMIT_RESET = 11'd1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LIMIT = 2'd1;

  // request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [CELL_W-1:0] freed_cell;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [CELL_W-1:0] cell_index;
    logic [CNT_W-1:0]  cells_in_use;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctl_state_t;

endpackage

// File: design/chunked_cell_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// chunked_cell_pool_allocator_top - fixed-size cell pool allocator
// one request at a time: accept, then execute once the head link is read
// done is high the cycle after execute, when the registered result is valid;
// the receiver cannot stall it
// synchronous reset empties the list and pool; chunk size 64, cell limit 1024
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunked_cell_pool_allocator_top
  import ccpa_pkg::*;
#(
  parameter int POOL_CELLS = DEFAULT_POOL_CELLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 done,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  ctl_cmd_t cmd;

  // config transfers are always taken
  assign cfg_ready = 1'b1;

  ccpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  ccpa_datapath #(
    .POOL_CELLS (POOL_CELLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// File: design/ccpa_ctrl.sv
// ----------------------------------------------------------------------------
// ccpa_ctrl
// two-state sequencer: takes a request, then runs one execute cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccpa_ctrl
  import ccpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output ctl_cmd_t cmd
);

  ctl_state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands and status
  assign busy     = (state == ST_EXEC);
  assign cmd.load = (state == ST_IDLE) && start;
  assign cmd.exec = (state == ST_EXEC);

endmodule

// File: design/ccpa_datapath.sv
// ----------------------------------------------------------------------------
// ccpa_datapath
// free list memory, bump pointer, chunk growth, use count and config regs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccpa_datapath
  import ccpa_pkg::*;
#(
  parameter int POOL_CELLS = DEFAULT_POOL_CELLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             cmd,
  input  req_t                 req,
  output logic                 done,
  output rsp_t                 rsp,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  localparam int AW = $clog2(POOL_CELLS);

  // configuration registers
  logic [CNT_W-1:0] chunk_size;
  logic [CNT_W-1:0] cell_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size <= CHUNK_SIZE_RESET;
      cell_limit <= CELL_LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_CHUNK_SIZE: chunk_size <= cfg_data;
        CFG_CELL_LIMIT: cell_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // allocator state
  logic [CELL_W-1:0] free_head, free_head_next;
  logic              free_valid, free_valid_next;
  logic [CNT_W-1:0]  bump_next, bump_next_next;
  logic [CNT_W-1:0]  allotted, allotted_next;
  logic [CNT_W-1:0]  in_use, in_use_next;

  // latched request and link read data
  req_t              pend;
  logic [CELL_W-1:0] rd_link;

  // link memory
  logic [CELL_W-1:0] next_link [POOL_CELLS];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;

  assign rd_addr = AW'(free_head);
  assign wr_addr = AW'(pend.freed_cell);

  // head link is read every cycle into the registered rd_link
  always_ff @(posedge clk) begin
    if (wr_en) next_link[wr_addr] <= wr_data;
    rd_link <= next_link[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) pend <= req;
  end

  // request execution
  logic              granted;
  logic [CELL_W-1:0] grant_cell;
  logic              bump_ok;
  logic [CNT_W-1:0]  alloc_eff;
  logic [CNT_W:0]    grow_sum;

  always_comb begin
    free_head_next  = free_head;
    free_valid_next = free_valid;
    bump_next_next  = bump_next;
    allotted_next   = allotted;
    in_use_next     = in_use;
    granted         = 1'b0;
    grant_cell      = '0;
    wr_en           = 1'b0;
    wr_data         = free_valid ? free_head : pend.freed_cell;
    bump_ok         = 1'b1;
    alloc_eff       = allotted;
    grow_sum        = {1'b0, allotted} + {1'b0, chunk_size};

    if (pend.action == ACT_ALLOC) begin
      if (free_valid) begin
        // pop; a self link marks the list end
        grant_cell = free_head;
        granted    = 1'b1;
        if (rd_link == free_head) free_valid_next = 1'b0;
        else free_head_next = rd_link;
      end else begin
        // bump region, growing by one chunk when used up, up to the cell limit
        if (bump_next >= allotted) begin
          if (allotted == '0) alloc_eff = chunk_size;
          else if (grow_sum <= {1'b0, cell_limit}) alloc_eff = grow_sum[CNT_W-1:0];
          else bump_ok = 1'b0;
          if (bump_ok) begin
            allotted_next = alloc_eff;
            if (bump_next >= alloc_eff) bump_ok = 1'b0;
          end
        end
        if (32'(bump_next) >= POOL_CELLS) bump_ok = 1'b0;
        if (bump_ok) begin
          grant_cell     = bump_next[CELL_W-1:0];
          bump_next_next = bump_next + 1'b1;
          granted        = 1'b1;
        end
      end
      if (granted && (in_use != '1)) in_use_next = in_use + 1'b1;
    end else if (32'(pend.freed_cell) < POOL_CELLS) begin
      // push; first cell on an empty list links to itself
      wr_en           = cmd.exec;
      free_head_next  = pend.freed_cell;
      free_valid_next = 1'b1;
      granted         = 1'b1;
      if (in_use != '0) in_use_next = in_use - 1'b1;
    end
  end

  // state update on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      free_valid <= 1'b0;
      bump_next  <= '0;
      allotted   <= '0;
      in_use     <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        free_head  <= free_head_next;
        free_valid <= free_valid_next;
        bump_next  <= bump_next_next;
        allotted   <= allotted_next;
        in_use     <= in_use_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.granted      <= granted;
      rsp.cell_index   <= grant_cell;
      rsp.cells_in_use <= in_use_next;
    end
  end

endmodule

// File: design/ccpa_checker.sv
// ----------------------------------------------------------------------------
// ccpa_checker
// port-level checks on request and result sequencing of the allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chunked_cell_pool_allocator_top_macros.svh"

module ccpa_checker
  import ccpa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  // an accepted request holds off the next one
  `CCPA_ASSERT_NEXT(a_busy_after_accept, clk, rst, start && !busy, busy, "no busy after accept")

  // a result comes out the cycle after the block was busy
  `CCPA_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy) && !busy, "stray result")

  // one result per request
  `CCPA_ASSERT_NEXT(a_single_done, clk, rst, done, !done, "repeated result")

  // a refused request reports cell zero
  `CCPA_ASSERT_NOW(a_refused_zero, clk, rst, done && !rsp.granted, rsp.cell_index == '0, "bad cell")

endmodule

bind chunked_cell_pool_allocator_top ccpa_checker u_ccpa_checker (.*);
